[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcsm_pkg.sv]
// shared types and constants of the colour-difference selection mask
`timescale 1ns / 1ps

package pcsm_pkg;

    // default channel width and channel count
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int NUM_CHANNELS     = 4;
    localparam int CFG_INDEX_BITS   = 3;

    // register indexes of the configuration channel
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REF_CHAN0     = 3'd0,
        CFG_REF_CHAN1     = 3'd1,
        CFG_REF_CHAN2     = 3'd2,
        CFG_REF_CHAN3     = 3'd3,
        CFG_THRESHOLD     = 3'd4,
        CFG_CRITERION     = 3'd5,
        CFG_CHANNEL_COUNT = 3'd6,
        CFG_OPTION_BITS   = 3'd7
    } cfg_reg_t;

    // distance criteria
    typedef enum logic [2:0] {
        CRIT_COMPOSITE  = 3'd0,
        CRIT_RED        = 3'd1,
        CRIT_GREEN      = 3'd2,
        CRIT_BLUE       = 3'd3,
        CRIT_HUE        = 3'd4,
        CRIT_SATURATION = 3'd5,
        CRIT_VALUE      = 3'd6,
        CRIT_ALPHA      = 3'd7
    } crit_t;

    // reset channel count: four channels, last one alpha
    localparam logic [2:0] CHANNEL_COUNT_RST = 3'd4;

    // option bit positions
    localparam int OPT_ANTIALIAS   = 0;
    localparam int OPT_TRANSPARENT = 1;

    // mode settings handed from the register file to the datapath
    typedef struct packed {
        crit_t      criterion;
        logic [2:0] channel_count;
        logic       antialias;
        logic       transp_req;
    } mode_t;

endpackage

[rtl/pcsm_cfg.sv]
// configuration register file of the selection mask
`timescale 1ns / 1ps

module pcsm_cfg
    import pcsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0]                 wr_index,
    input  logic [CHANNEL_BITS-1:0]                   wr_data,
    output logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] ref_chan,
    output logic [CHANNEL_BITS-1:0]                   threshold,
    output mode_t                                     mode
);

    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] ref_chan_reg;
    logic [CHANNEL_BITS-1:0]                   threshold_reg;
    logic [2:0]                                criterion_reg;
    logic [2:0]                                channel_count_reg;
    logic [1:0]                                option_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_chan_reg      <= '0;
            threshold_reg     <= '0;
            criterion_reg     <= CRIT_COMPOSITE;
            channel_count_reg <= CHANNEL_COUNT_RST;
            option_reg        <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_REF_CHAN0:     ref_chan_reg[0]   <= wr_data;
                CFG_REF_CHAN1:     ref_chan_reg[1]   <= wr_data;
                CFG_REF_CHAN2:     ref_chan_reg[2]   <= wr_data;
                CFG_REF_CHAN3:     ref_chan_reg[3]   <= wr_data;
                CFG_THRESHOLD:     threshold_reg     <= wr_data;
                CFG_CRITERION:     criterion_reg     <= wr_data[2:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= wr_data[2:0];
                CFG_OPTION_BITS:   option_reg        <= wr_data[1:0];
                default:           ref_chan_reg      <= ref_chan_reg;
            endcase
        end
    end

    // register outputs
    assign ref_chan             = ref_chan_reg;
    assign threshold            = threshold_reg;
    assign mode.criterion       = crit_t'(criterion_reg);
    assign mode.channel_count   = channel_count_reg;
    assign mode.antialias       = option_reg[OPT_ANTIALIAS];
    assign mode.transp_req      = option_reg[OPT_TRANSPARENT];

endmodule

[rtl/pcsm_dist.sv]
// channel differences and distance selection, two register stages
`timescale 1ns / 1ps

module pcsm_dist
    import pcsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      in_valid,
    input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pixel,
    input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] ref_chan,
    input  mode_t                                     mode,
    output logic                                      out_valid,
    output logic [CHANNEL_BITS-1:0]                   out_dist,
    output logic                                      out_kill
);

    localparam logic [CHANNEL_BITS-1:0] FULL = '1;

    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] diff;
    logic                                      alpha_mode;
    logic                                      use_ch1;
    logic                                      use_ch2;
    logic                                      transparent;
    logic                                      kill;
    logic [CHANNEL_BITS-1:0]                   max01;
    logic [CHANNEL_BITS-1:0]                   max012;
    logic [CHANNEL_BITS-1:0]                   hue_wrap;
    logic [CHANNEL_BITS-1:0]                   sel_dist;

    logic                                      s1_valid_reg;
    logic                                      s1_kill_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] s1_diff_reg;
    logic                                      s2_valid_reg;
    logic                                      s2_kill_reg;
    logic [CHANNEL_BITS-1:0]                   s2_dist_reg;

    // channel count clamps to 1..4, four or more means alpha
    assign alpha_mode  = (mode.channel_count >= 3'd4);
    assign use_ch1     = (mode.channel_count >= 3'd2);
    assign use_ch2     = (mode.channel_count >= 3'd3);
    assign transparent = mode.transp_req && alpha_mode && (ref_chan[3] == '0);
    assign kill        = !transparent && alpha_mode && (pixel[3] == '0);

    // absolute difference per channel
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            diff[i] = (pixel[i] > ref_chan[i]) ? (pixel[i] - ref_chan[i])
                                               : (ref_chan[i] - pixel[i]);
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kill_reg <= kill;
            s1_diff_reg <= diff;
        end
    end

    // largest colour difference and hue wraparound
    assign max01    = (use_ch1 && (s1_diff_reg[1] > s1_diff_reg[0])) ? s1_diff_reg[1]
                                                                   : s1_diff_reg[0];
    assign max012   = (use_ch2 && (s1_diff_reg[2] > max01)) ? s1_diff_reg[2] : max01;
    assign hue_wrap = ((FULL - s1_diff_reg[0]) < s1_diff_reg[0]) ? (FULL - s1_diff_reg[0])
                                                                  : s1_diff_reg[0];

    // distance by criterion
    always_comb
    begin
        if (transparent)
        begin
            sel_dist = s1_diff_reg[3];
        end
        else
        begin
            unique case (mode.criterion) inside
                CRIT_COMPOSITE:                sel_dist = max012;
                CRIT_RED:                      sel_dist = s1_diff_reg[0];
                CRIT_HUE:                      sel_dist = hue_wrap;
                CRIT_GREEN, CRIT_SATURATION:   sel_dist = s1_diff_reg[1];
                CRIT_BLUE, CRIT_VALUE:         sel_dist = s1_diff_reg[2];
                default:                       sel_dist = s1_diff_reg[3];
            endcase
        end
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_kill_reg <= s1_kill_reg;
            s2_dist_reg <= sel_dist;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_dist  = s2_dist_reg;
    assign out_kill  = s2_kill_reg;

endmodule

[rtl/pcsm_ramp.sv]
// threshold compare and ramp numerator, one register stage
`timescale 1ns / 1ps

module pcsm_ramp
    import pcsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [CHANNEL_BITS-1:0]     in_dist,
    input  logic                        in_kill,
    input  logic [CHANNEL_BITS-1:0]     threshold,
    input  logic                        antialias,
    output logic                        out_valid,
    output logic                        out_need_div,
    output logic [CHANNEL_BITS-1:0]     out_acc,
    output logic [2*CHANNEL_BITS-1:0]   out_num
);

    localparam logic [CHANNEL_BITS-1:0] FULL = '1;

    logic [CHANNEL_BITS+1:0]   three_t;
    logic [CHANNEL_BITS+1:0]   two_d;
    logic [CHANNEL_BITS+1:0]   ramp_r;
    logic [CHANNEL_BITS-1:0]   ramp_lo;
    logic [2*CHANNEL_BITS-1:0] num;
    logic                      aa_on;
    logic                      need_div;
    logic [CHANNEL_BITS-1:0]   res;

    logic                      valid_reg;
    logic                      need_div_reg;
    logic [CHANNEL_BITS-1:0]   acc_reg;
    logic [2*CHANNEL_BITS-1:0] num_reg;

    // 3t, 2d and FULL * (3t - 2d) by shift and subtract
    assign three_t = {2'b00, threshold} + {1'b0, threshold, 1'b0};
    assign two_d   = {1'b0, in_dist, 1'b0};
    assign ramp_r  = three_t - two_d;
    assign ramp_lo = ramp_r[CHANNEL_BITS-1:0];
    assign num     = {ramp_lo, {CHANNEL_BITS{1'b0}}}
                   - {{CHANNEL_BITS{1'b0}}, ramp_lo};
    assign aa_on   = antialias && (threshold != '0);

    // hard decisions; the ramp middle goes to the divider
    always_comb
    begin
        need_div = 1'b0;
        res      = '0;
        if (in_kill)
        begin
            res = '0;
        end
        else if (!aa_on)
        begin
            res = (in_dist <= threshold) ? FULL : '0;
        end
        else if (two_d >= three_t)
        begin
            res = '0;
        end
        else if (in_dist <= threshold)
        begin
            res = FULL;
        end
        else
        begin
            need_div = 1'b1;
        end
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            need_div_reg <= need_div;
            acc_reg      <= res;
            num_reg      <= num;
        end
    end

    assign out_valid    = valid_reg;
    assign out_need_div = need_div_reg;
    assign out_acc      = acc_reg;
    assign out_num      = num_reg;

endmodule

[rtl/pcsm_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module pcsm_div
    import pcsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic                      in_need_div,
    input  logic [CHANNEL_BITS-1:0]   in_acc,
    input  logic [2*CHANNEL_BITS-1:0] in_num,
    input  logic [CHANNEL_BITS-1:0]   divisor,
    output logic                      out_valid,
    output logic [CHANNEL_BITS-1:0]   out_value
);

    localparam int STEPS = CHANNEL_BITS;

    // per stage inputs and next values
    logic                    vld_in   [STEPS];
    logic                    div_in   [STEPS];
    logic [CHANNEL_BITS-1:0] rem_in   [STEPS];
    logic [CHANNEL_BITS-1:0] low_in   [STEPS];
    logic [CHANNEL_BITS-1:0] acc_in   [STEPS];
    logic [CHANNEL_BITS:0]   shifted  [STEPS];
    logic [CHANNEL_BITS:0]   sub      [STEPS];
    logic                    ge       [STEPS];
    logic [CHANNEL_BITS-1:0] rem_next [STEPS];
    logic [CHANNEL_BITS-1:0] low_next [STEPS];
    logic [CHANNEL_BITS-1:0] acc_next [STEPS];

    // stage registers
    logic                    vld_reg  [STEPS];
    logic                    div_reg  [STEPS];
    logic [CHANNEL_BITS-1:0] rem_reg  [STEPS];
    logic [CHANNEL_BITS-1:0] low_reg  [STEPS];
    logic [CHANNEL_BITS-1:0] acc_reg  [STEPS];

    // one compare and subtract per stage; the high half starts below the divisor
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                vld_in[k] = in_valid;
                div_in[k] = in_need_div;
                rem_in[k] = in_num[2*CHANNEL_BITS-1:CHANNEL_BITS];
                low_in[k] = in_num[CHANNEL_BITS-1:0];
                acc_in[k] = in_need_div ? '0 : in_acc;
            end
            else
            begin
                vld_in[k] = vld_reg[k-1];
                div_in[k] = div_reg[k-1];
                rem_in[k] = rem_reg[k-1];
                low_in[k] = low_reg[k-1];
                acc_in[k] = acc_reg[k-1];
            end
            shifted[k]  = {rem_in[k], low_in[k][CHANNEL_BITS-1]};
            sub[k]      = shifted[k] - {1'b0, divisor};
            ge[k]       = (shifted[k] >= {1'b0, divisor});
            rem_next[k] = ge[k] ? sub[k][CHANNEL_BITS-1:0] : shifted[k][CHANNEL_BITS-1:0];
            low_next[k] = {low_in[k][CHANNEL_BITS-2:0], 1'b0};
            acc_next[k] = div_in[k] ? {acc_in[k][CHANNEL_BITS-2:0], ge[k]} : acc_in[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                div_reg[k] <= div_in[k];
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_value = acc_reg[STEPS-1];

endmodule

[rtl/pixel_color_select_mask_top.sv]
// top level of the colour-difference selection mask pipeline
//
//   channel   group                        direction  word
//   pixels    s_tvalid s_tready s_tdata    in         pixel_ch0..pixel_ch3
//   mask      m_tvalid m_tready m_tdata    out        mask_value
//   config    cfg_valid cfg_ready          in         cfg_index, cfg_data
//
// one pixel per clock while the skid register is empty; the stages are two
// difference stages, one compare stage, one divider stage per quotient bit
// and the output register. the divider depth sets the latency.
// rst_n clears all valid bits and loads the register reset values.
// a stalled output fills a one-word skid register, which then holds the
// whole pipeline; the config channel is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pixel_color_select_mask_top
    import pcsm_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    localparam int IN_W  = ((NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((CHANNEL_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // pixel channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3
    // mask channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // mask_value
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CHANNEL_BITS-1:0]   cfg_data
);

    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] ref_chan;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pixel;
    logic [CHANNEL_BITS-1:0]                   threshold;
    mode_t                                     mode;

    logic                      pipe_en;
    logic                      dist_valid;
    logic [CHANNEL_BITS-1:0]   dist_value;
    logic                      dist_kill;
    logic                      ramp_valid;
    logic                      ramp_need_div;
    logic [CHANNEL_BITS-1:0]   ramp_acc;
    logic [2*CHANNEL_BITS-1:0] ramp_num;
    logic                      div_valid;
    logic [CHANNEL_BITS-1:0]   div_value;
    logic                      word_out;
    logic                      slot_free;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [CHANNEL_BITS-1:0]   out_data_reg;
    logic [CHANNEL_BITS-1:0]   out_data_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    logic [CHANNEL_BITS-1:0]   skid_data_reg;

    // register file
    assign cfg_ready = 1'b1;

    pcsm_cfg #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .ref_chan  (ref_chan),
        .threshold (threshold),
        .mode      (mode)
    );

    // unpack pixel word
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            pixel[i] = s_tdata[i*CHANNEL_BITS +: CHANNEL_BITS];
        end
    end

    // pipeline moves whenever the skid register is empty
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    pcsm_dist #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (pipe_en),
        .in_valid  (s_tvalid),
        .pixel     (pixel),
        .ref_chan  (ref_chan),
        .mode      (mode),
        .out_valid (dist_valid),
        .out_dist  (dist_value),
        .out_kill  (dist_kill)
    );

    pcsm_ramp #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_ramp (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (pipe_en),
        .in_valid     (dist_valid),
        .in_dist      (dist_value),
        .in_kill      (dist_kill),
        .threshold    (threshold),
        .antialias    (mode.antialias),
        .out_valid    (ramp_valid),
        .out_need_div (ramp_need_div),
        .out_acc      (ramp_acc),
        .out_num      (ramp_num)
    );

    pcsm_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (pipe_en),
        .in_valid    (ramp_valid),
        .in_need_div (ramp_need_div),
        .in_acc      (ramp_acc),
        .in_num      (ramp_num),
        .divisor     (threshold),
        .out_valid   (div_valid),
        .out_value   (div_value)
    );

    // output register and skid register
    assign word_out  = div_valid && pipe_en;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = word_out;
                out_data_next  = div_value;
            end
        end
        else if (word_out)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (!slot_free && word_out)
        begin
            skid_data_reg <= div_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // checks
    `PCSM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a word while the output register is empty")
    `PCSM_ASSERT_NXT(a_stall_to_skid, out_valid_reg && !m_tready && word_out,
        skid_valid_reg && out_valid_reg, "stalled word was not caught by the skid register")
    `PCSM_ASSERT_NXT(a_word_to_out, slot_free && !skid_valid_reg && word_out,
        out_valid_reg && !skid_valid_reg, "finished word did not reach the output register")

endmodule

[bench/tb.sv]
// testbench of the colour-difference selection mask: directed pixel table, then random pixels
`timescale 1ns / 1ps

module tb;
    import pcsm_pkg::*;

    localparam int PIPE_LAT     = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_PIXELS = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int FULL         = 255;
    localparam int AA           = 1 << OPT_ANTIALIAS;
    localparam int TR           = 1 << OPT_TRANSPARENT;

    // register set as the bench keeps it
    typedef struct packed {
        logic [3:0][7:0] ref_px;
        logic [7:0]      thr;
        crit_t           crit;
        logic [2:0]      chans;
        logic [1:0]      opts;
    } mask_cfg_t;

    // one row of the directed table
    typedef struct {
        mask_cfg_t       cfg;
        logic [3:0][7:0] px;
        bit              known;
        logic [7:0]      mask;
    } pixel_case_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // mask_value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // typed expectation travelling beside the pixel word
    bit          px_known  = 1'b0;
    logic [7:0]  px_mask   = '0;

    mask_cfg_t   cur_cfg;
    logic [7:0]  expected_masks[$];
    int          errors        = 0;
    int          masks_checked = 0;
    int          pixels_sent   = 0;
    int          cfg_writes    = 0;
    int          idle_cycles   = 0;
    int          tx_mode       = 2;
    int          rx_mode       = 2;
    bit          hold_rx       = 1'b0;

    pixel_color_select_mask_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int absd(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // expected mask of one pixel under a register set
    function automatic logic [7:0] predict_mask(mask_cfg_t c, logic [3:0][7:0] px);
        int n;
        int d;
        int e;
        int t;
        int colours;
        int i;
        bit alpha_on;
        bit transp;
        bit ramp;
        n = c.chans;
        if (n < 1) n = 1;
        if (n > NUM_CHANNELS) n = NUM_CHANNELS;
        alpha_on = (n == NUM_CHANNELS);
        ramp     = c.opts[OPT_ANTIALIAS];
        transp   = c.opts[OPT_TRANSPARENT] && alpha_on && (c.ref_px[3] == 8'd0);
        t        = c.thr;
        d        = 0;
        // fully transparent pixel outside transparent selection
        if (!transp && alpha_on && px[3] == 8'd0)
            return 8'd0;
        if (transp)
            d = absd(px[3], c.ref_px[3]);
        else
        begin
            colours = alpha_on ? 3 : n;
            case (c.crit)
                CRIT_COMPOSITE:
                begin
                    for (i = 0; i < colours; i++)
                    begin
                        e = absd(px[i], c.ref_px[i]);
                        if (e > d) d = e;
                    end
                end
                CRIT_RED:                   d = absd(px[0], c.ref_px[0]);
                CRIT_HUE:
                begin
                    d = absd(px[0], c.ref_px[0]);
                    if (FULL - d < d) d = FULL - d;
                end
                CRIT_GREEN, CRIT_SATURATION: d = absd(px[1], c.ref_px[1]);
                CRIT_BLUE, CRIT_VALUE:       d = absd(px[2], c.ref_px[2]);
                default:                     d = absd(px[3], c.ref_px[3]);
            endcase
        end
        // hard threshold or linear ramp up to one and a half thresholds
        if (ramp && t > 0)
        begin
            if (2 * d >= 3 * t)
                return 8'd0;
            else if (d <= t)
                return 8'(FULL);
            else
                return 8'((FULL * (3 * t - 2 * d)) / t);
        end
        return (d > t) ? 8'd0 : 8'(FULL);
    endfunction

    function automatic mask_cfg_t mk_cfg(int r0, int r1, int r2, int r3, int t, crit_t cr,
                                         int ch, int op);
        mask_cfg_t c;
        c.ref_px[0] = 8'(r0);
        c.ref_px[1] = 8'(r1);
        c.ref_px[2] = 8'(r2);
        c.ref_px[3] = 8'(r3);
        c.thr       = 8'(t);
        c.crit      = cr;
        c.chans     = 3'(ch);
        c.opts      = 2'(op);
        return c;
    endfunction

    function automatic pixel_case_t mk_case(mask_cfg_t c, int p0, int p1, int p2, int p3,
                                            bit known, int m);
        pixel_case_t r;
        r.cfg   = c;
        r.px    = {8'(p3), 8'(p2), 8'(p1), 8'(p0)};
        r.known = known;
        r.mask  = 8'(m);
        return r;
    endfunction

    function automatic int draw_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // random channel value around a reference, clipped to the channel range
    function automatic logic [7:0] near(logic [7:0] r, int s);
        int v;
        v = int'(r) - s + int'($urandom_range(0, 2 * s));
        if (v < 0) v = 0;
        if (v > FULL) v = FULL;
        return 8'(v);
    endfunction

    // offer one pixel word and wait for it to be taken
    task automatic send_pixel(logic [3:0][7:0] px, bit known, logic [7:0] mask);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        px_known <= known;
        px_mask  <= mask;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every mask word is back and the pipeline has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_masks.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // write all registers back to back; junk fills unused upper bits
    task automatic load_cfg(mask_cfg_t c, logic [7:0] junk);
        cfg_reg_t   reg_id;
        logic [7:0] val;
        int         k;
        reg_id = reg_id.first();
        for (k = 0; k < 8; k++)
        begin
            case (reg_id)
                CFG_REF_CHAN0:     val = c.ref_px[0];
                CFG_REF_CHAN1:     val = c.ref_px[1];
                CFG_REF_CHAN2:     val = c.ref_px[2];
                CFG_REF_CHAN3:     val = c.ref_px[3];
                CFG_THRESHOLD:     val = c.thr;
                CFG_CRITERION:     val = {junk[7:3], c.crit};
                CFG_CHANNEL_COUNT: val = {junk[7:3], c.chans};
                default:           val = {junk[7:2], c.opts};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= reg_id;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            cfg_writes++;
            reg_id = reg_id.next();
        end
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // mask receiver with random stalls and one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            gap = draw_gap(rx_mode);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word accepted for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            // expectation for each accepted pixel word
            if (s_tvalid && s_tready)
            begin
                expected_masks.push_back(px_known ? px_mask : predict_mask(cur_cfg, s_tdata));
                pixels_sent++;
            end
            // compare each accepted mask word with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_masks.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected mask word %0d at %0t", m_tdata, $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    masks_checked++;
                    if (m_tdata !== want)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("mask mismatch at %0t: expected %0d, got %0d",
                                     $realtime, want, m_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        pixel_case_t     dir_cases[$];
        mask_cfg_t       c0;
        mask_cfg_t       c;
        logic [3:0][7:0] px;
        int              ph;
        int              k;
        int              i;
        int              span;

        c0      = mk_cfg(0, 0, 0, 0, 0, CRIT_COMPOSITE, CHANNEL_COUNT_RST, 0);
        cur_cfg = c0;

        // register values after reset
        dir_cases.push_back(mk_case(c0, 0, 0, 0, 255, 1, 255));
        dir_cases.push_back(mk_case(c0, 0, 0, 0, 0, 1, 0));
        dir_cases.push_back(mk_case(c0, 255, 0, 0, 1, 1, 0));
        // composite and single-channel criteria
        c = mk_cfg(100, 150, 200, 128, 20, CRIT_COMPOSITE, 4, 0);
        dir_cases.push_back(mk_case(c, 110, 140, 215, 7, 0, 0));
        dir_cases.push_back(mk_case(c, 100, 150, 221, 1, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_RED, 4, 0),
                                    95, 0, 255, 9, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_GREEN, 4, 0),
                                    0, 160, 0, 255, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_BLUE, 4, 0),
                                    0, 0, 189, 255, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_SATURATION, 4, 0),
                                    255, 141, 0, 3, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_VALUE, 4, 0),
                                    0, 255, 211, 3, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 150, 200, 128, 10, CRIT_ALPHA, 4, 0),
                                    0, 0, 0, 139, 0, 0));
        // hue wraps round the channel range
        dir_cases.push_back(mk_case(mk_cfg(10, 0, 0, 0, 20, CRIT_HUE, 4, 0),
                                    250, 0, 0, 255, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(0, 0, 0, 0, 0, CRIT_HUE, 4, 0),
                                    255, 0, 0, 255, 0, 0));
        // antialias ramp edges
        c = mk_cfg(100, 100, 100, 50, 40, CRIT_COMPOSITE, 4, AA);
        dir_cases.push_back(mk_case(c, 140, 100, 100, 50, 0, 0));
        dir_cases.push_back(mk_case(c, 150, 100, 100, 50, 0, 0));
        dir_cases.push_back(mk_case(c, 159, 100, 100, 50, 0, 0));
        dir_cases.push_back(mk_case(c, 160, 100, 100, 50, 0, 0));
        // antialias with zero threshold falls back to the hard compare
        c = mk_cfg(100, 100, 100, 50, 0, CRIT_COMPOSITE, 4, AA);
        dir_cases.push_back(mk_case(c, 100, 100, 100, 50, 0, 0));
        dir_cases.push_back(mk_case(c, 101, 100, 100, 50, 0, 0));
        // transparent selection, and requested but reference alpha nonzero
        c = mk_cfg(30, 30, 30, 0, 10, CRIT_RED, 4, TR);
        dir_cases.push_back(mk_case(c, 0, 0, 0, 0, 0, 0));
        dir_cases.push_back(mk_case(c, 0, 0, 0, 200, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(30, 30, 30, 5, 10, CRIT_RED, 4, TR),
                                    0, 0, 0, 0, 1, 0));
        // channel count zero, above four, and criterion on a missing channel
        dir_cases.push_back(mk_case(mk_cfg(100, 100, 100, 100, 5, CRIT_COMPOSITE, 0, 0),
                                    100, 0, 0, 0, 0, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 100, 100, 100, 5, CRIT_COMPOSITE, 7, 0),
                                    100, 100, 100, 0, 1, 0));
        dir_cases.push_back(mk_case(mk_cfg(100, 100, 100, 100, 5, CRIT_BLUE, 1, 0),
                                    100, 0, 100, 0, 0, 0));
        // full threshold with ramp and transparent request
        dir_cases.push_back(mk_case(mk_cfg(0, 0, 0, 0, 255, CRIT_COMPOSITE, 4, AA | TR),
                                    255, 255, 255, 255, 0, 0));

        @(posedge rst_n);
        @(posedge clk);

        // directed table
        foreach (dir_cases[k])
        begin
            if (dir_cases[k].cfg != cur_cfg)
            begin
                drain();
                load_cfg(dir_cases[k].cfg, 8'h00);
            end
            send_pixel(dir_cases[k].px, dir_cases[k].known, dir_cases[k].mask);
        end

        // random phases, one register set each
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (i = 0; i < 4; i++)
                c.ref_px[i] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0)
                c.ref_px[3] = 8'd0;
            c.thr   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 60));
            c.crit  = crit_t'((ph < 8) ? ph : $urandom_range(0, 7));
            c.chans = $urandom_range(0, 1) ? 3'(NUM_CHANNELS) : 3'($urandom_range(0, 7));
            c.opts  = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
            // register extremes
            if (ph == 0)
                c.thr = 8'd0;
            if (ph == 1 || ph == 13)
            begin
                c.thr    = 8'd255;
                c.ref_px = (ph == 1) ? {4{8'd255}} : '0;
            end
            drain();
            load_cfg(c, 8'($urandom));
            tx_mode = (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 2);
            rx_mode = (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 2);
            span    = int'(c.thr) * 3 / 2 + 8;
            for (k = 0; k < PHASE_PIXELS; k++)
            begin
                // long output stall while pixels keep coming
                if (ph == 3 && k == 20)
                    hold_rx = 1'b1;
                // sender waits for every mask word to return
                if (ph == 5 && k == 50)
                    drain();
                for (i = 0; i < 4; i++)
                    px[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : near(c.ref_px[i], span);
                if ($urandom_range(0, 7) == 0)
                    px[3] = 8'd0;
                send_pixel(px, 1'b0, 8'd0);
            end
        end

        drain();
        $display("checked %0d mask words for %0d pixels (%0d directed, rest random)",
                 masks_checked, pixels_sent, dir_cases.size());
        $display("%0d register writes: every criterion, channel count and option setting",
                 cfg_writes);
        if (errors == 0 && expected_masks.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[pixel_color_select_mask_top.f]
+incdir+rtl
rtl/pcsm_pkg.sv
rtl/pcsm_cfg.sv
rtl/pcsm_dist.sv
rtl/pcsm_ramp.sv
rtl/pcsm_div.sv
rtl/pixel_color_select_mask_top.sv
bench/tb.sv
